@@ hdl/eiqu_pkg.sv @@
// Shared types, constants, tables and the step program of the attitude update core.
package eiqu_pkg;

  // Field widths and fixed-point formats
  localparam int QUAT_BITS  = 16;
  localparam int ANGLE_BITS = 16;
  localparam int QFRAC      = QUAT_BITS - 1;
  localparam int AFRAC      = ANGLE_BITS - 4;
  localparam int IFRAC      = 30;

  // Internal datapath widths
  localparam int DW    = 36;          // inner values, 30 fraction bits
  localparam int PW    = 2 * DW;      // full product
  localparam int MPW   = 54;          // pole test products
  localparam int AW    = 37;          // unwrapped angles, 2^32 units per turn
  localparam int CW    = 38;          // CORDIC x and y
  localparam int RW    = 64;          // square root radicand
  localparam int ITERS = 30;
  localparam int IT_W  = $clog2(ITERS);
  localparam int SQ_STEPS = RW / 2;
  localparam int SQ_K_W   = $clog2(SQ_STEPS);

  localparam logic signed [DW-1:0] RAD_SCALE = 36'sd2734261102;
  localparam logic signed [DW-1:0] POLE_NUM  = 36'sd100000;
  localparam logic signed [DW-1:0] POLE_DEN  = 36'sd49999;
  localparam logic signed [AW-1:0] PITCH_HI  = 37'sd1073607622;
  localparam logic signed [AW-1:0] PITCH_LO  = -37'sd1073744335;
  localparam logic signed [AW-1:0] QUARTER   = 37'sd1073741824;
  localparam logic signed [CW-1:0] CORDIC_K  = 38'sd652032874;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] yaw_delta;
    logic signed [ANGLE_BITS-1:0] pitch_delta;
    logic signed [ANGLE_BITS-1:0] roll_delta;
  } in_word_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } out_word_t;

  // Datapath step codes
  typedef enum logic [5:0] {
    OP_NONE,
    OP_SQW, OP_SQX, OP_SQY, OP_SQZ,
    OP_XY, OP_TEST, OP_UNIT,
    OP_AY, OP_AP, OP_AR,
    OP_T100, OP_U49, OP_POLE,
    OP_YW, OP_XZ, OP_XW, OP_YZ,
    OP_VEC_YAW, OP_SET_YAW,
    OP_UU, OP_TT, OP_SQRT,
    OP_VEC_PITCH, OP_SET_PITCH,
    OP_VEC_ROLL, OP_SET_ROLL,
    OP_ROT_YAW, OP_SET_1, OP_ROT_PITCH, OP_SET_2, OP_ROT_ROLL, OP_SET_3,
    OP_C1C2, OP_S1S2, OP_S1C2, OP_C1S2,
    OP_W_A, OP_W_B, OP_X_A, OP_X_B, OP_Y_A, OP_Y_B, OP_Z_A, OP_Z_B
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  localparam int PROG_LEN = 44;
  localparam int PC_W     = $clog2(PROG_LEN);

  // Step program, one step per entry
  function automatic op_e prog_op(input logic [PC_W-1:0] pc);
    op_e o;
    unique case (pc)
      6'd0:  o = OP_SQW;
      6'd1:  o = OP_SQX;
      6'd2:  o = OP_SQY;
      6'd3:  o = OP_SQZ;
      6'd4:  o = OP_XY;
      6'd5:  o = OP_TEST;
      6'd6:  o = OP_UNIT;
      6'd7:  o = OP_AY;
      6'd8:  o = OP_AP;
      6'd9:  o = OP_AR;
      6'd10: o = OP_T100;
      6'd11: o = OP_U49;
      6'd12: o = OP_POLE;
      6'd13: o = OP_YW;
      6'd14: o = OP_XZ;
      6'd15: o = OP_XW;
      6'd16: o = OP_YZ;
      6'd17: o = OP_VEC_YAW;
      6'd18: o = OP_SET_YAW;
      6'd19: o = OP_UU;
      6'd20: o = OP_TT;
      6'd21: o = OP_SQRT;
      6'd22: o = OP_VEC_PITCH;
      6'd23: o = OP_SET_PITCH;
      6'd24: o = OP_VEC_ROLL;
      6'd25: o = OP_SET_ROLL;
      6'd26: o = OP_ROT_YAW;
      6'd27: o = OP_SET_1;
      6'd28: o = OP_ROT_PITCH;
      6'd29: o = OP_SET_2;
      6'd30: o = OP_ROT_ROLL;
      6'd31: o = OP_SET_3;
      6'd32: o = OP_C1C2;
      6'd33: o = OP_S1S2;
      6'd34: o = OP_S1C2;
      6'd35: o = OP_C1S2;
      6'd36: o = OP_W_A;
      6'd37: o = OP_W_B;
      6'd38: o = OP_X_A;
      6'd39: o = OP_X_B;
      6'd40: o = OP_Y_A;
      6'd41: o = OP_Y_B;
      6'd42: o = OP_Z_A;
      6'd43: o = OP_Z_B;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  // Steps that start a multi-cycle unit
  function automatic logic op_waits(input op_e o);
    logic w;
    case (o) inside
      OP_VEC_YAW, OP_VEC_PITCH, OP_VEC_ROLL, OP_SQRT,
      OP_ROT_YAW, OP_ROT_PITCH, OP_ROT_ROLL: w = 1'b1;
      default: w = 1'b0;
    endcase
    return w;
  endfunction

  // Arctangent of 2^-i in angle units
  function automatic logic signed [AW-1:0] atan_at(input logic [IT_W-1:0] idx);
    logic signed [AW-1:0] a;
    unique case (idx)
      5'd0:  a = 37'sd536870912;
      5'd1:  a = 37'sd316933406;
      5'd2:  a = 37'sd167458907;
      5'd3:  a = 37'sd85004756;
      5'd4:  a = 37'sd42667331;
      5'd5:  a = 37'sd21354465;
      5'd6:  a = 37'sd10679838;
      5'd7:  a = 37'sd5340245;
      5'd8:  a = 37'sd2670163;
      5'd9:  a = 37'sd1335087;
      5'd10: a = 37'sd667544;
      5'd11: a = 37'sd333772;
      5'd12: a = 37'sd166886;
      5'd13: a = 37'sd83443;
      5'd14: a = 37'sd41722;
      5'd15: a = 37'sd20861;
      5'd16: a = 37'sd10430;
      5'd17: a = 37'sd5215;
      5'd18: a = 37'sd2608;
      5'd19: a = 37'sd1304;
      5'd20: a = 37'sd652;
      5'd21: a = 37'sd326;
      5'd22: a = 37'sd163;
      5'd23: a = 37'sd81;
      5'd24: a = 37'sd41;
      5'd25: a = 37'sd20;
      5'd26: a = 37'sd10;
      5'd27: a = 37'sd5;
      5'd28: a = 37'sd3;
      5'd29: a = 37'sd1;
      default: a = 37'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/eiqu_cordic.sv @@
// Shared iterative CORDIC unit, vectoring or rotation, one micro-rotation per cycle.
module eiqu_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           vec_mode_i,
  input  logic signed [eiqu_pkg::CW-1:0] x_i,
  input  logic signed [eiqu_pkg::CW-1:0] y_i,
  input  logic signed [eiqu_pkg::AW-1:0] z_i,
  output logic                           busy_o,
  output logic signed [eiqu_pkg::CW-1:0] x_o,
  output logic signed [eiqu_pkg::CW-1:0] y_o,
  output logic signed [eiqu_pkg::AW-1:0] z_o
);
  import eiqu_pkg::*;

  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [AW-1:0] z_q, at;
  logic [IT_W-1:0]      it_q;
  logic                 run_q, vec_q, pos;

  // Pick the turn direction and the shifted terms
  assign pos = vec_q ? !(y_q > 0) : (z_q >= 0);
  assign xs  = x_q >>> it_q;
  assign ys  = y_q >>> it_q;
  assign at  = atan_at(it_q);

  // Hold the run flag and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      it_q  <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      it_q  <= '0;
    end else if (run_q) begin
      if (it_q == IT_W'(ITERS - 1)) begin
        run_q <= 1'b0;
      end else begin
        it_q <= it_q + 1'b1;
      end
    end
  end

  // Advance the vector
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      vec_q <= vec_mode_i;
    end else if (run_q) begin
      if (pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign busy_o = run_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

@@ hdl/eiqu_isqrt.sv @@
// Bit-pair integer square root, one result bit per cycle.
module eiqu_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [eiqu_pkg::RW-1:0] n_i,
  output logic                    busy_o,
  output logic [eiqu_pkg::DW-1:0] root_o
);
  import eiqu_pkg::*;

  logic [RW-1:0]     n_q, r_q, bitv, trial;
  logic [SQ_K_W-1:0] k_q;
  logic              run_q, ge;

  assign bitv  = RW'(1) << {k_q, 1'b0};
  assign trial = r_q + bitv;
  assign ge    = n_q >= trial;

  // Hold the run flag and bit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      k_q   <= SQ_K_W'(SQ_STEPS - 1);
    end else if (run_q) begin
      if (k_q == '0) begin
        run_q <= 1'b0;
      end else begin
        k_q <= k_q - 1'b1;
      end
    end
  end

  // Advance remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      r_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bitv;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign busy_o = run_q;
  assign root_o = r_q[DW-1:0];

endmodule

@@ hdl/eiqu_datapath.sv @@
// Datapath: attitude register, shared multiplier, CORDIC and square root units.
module eiqu_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eiqu_pkg::cmd_t       cmd_i,
  input  eiqu_pkg::in_word_t   in_word_i,
  output eiqu_pkg::stat_t      stat_o,
  output eiqu_pkg::out_word_t  out_word_o
);
  import eiqu_pkg::*;

  typedef enum logic [1:0] {POLE_NONE, POLE_NORTH, POLE_SOUTH} pole_e;

  localparam int OSH = IFRAC - QFRAC;
  localparam int ASH = AFRAC + 2;
  localparam logic signed [DW-1:0] QMAX = DW'((1 <<< (QUAT_BITS - 1)) - 1);
  localparam logic signed [DW-1:0] QMIN = -QMAX - DW'(1);

  function automatic logic signed [DW-1:0] to_inner(input logic signed [QUAT_BITS-1:0] q);
    return DW'(q) <<< OSH;
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] to_outer(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    r = (v + (DW'(1) <<< (OSH - 1))) >>> OSH;
    if (r > QMAX) r = QMAX;
    if (r < QMIN) r = QMIN;
    return QUAT_BITS'(r);
  endfunction

  logic signed [QUAT_BITS-1:0]  att_q [4];
  logic signed [ANGLE_BITS-1:0] dy_q, dp_q, dr_q;
  logic signed [DW-1:0] sqw_q, sqx_q, sqy_q, sqz_q, fxy_q, test_q, unit_q;
  logic signed [DW-1:0] fyw_q, fxz_q, fxw_q, fyz_q;
  logic signed [DW-1:0] c1_q, s1_q, c2_q, s2_q, c3_q, s3_q;
  logic signed [DW-1:0] c1c2_q, s1s2_q, s1c2_q, c1s2_q, pa_q;
  logic signed [DW-1:0] pd_q [4];
  logic signed [AW-1:0] ay_q, ap_q, ar_q, yaw_q, pitch_q, roll_q;
  logic signed [MPW-1:0] m1_q, m2_q;
  logic signed [RW-1:0] uu_q, tt_q, rad;
  pole_e                pole_q, pole_d;
  logic                 vzero_q, flip_q;

  logic signed [DW-1:0] wi, xi, yi, zi, u, t;
  logic signed [DW-1:0] mul_a, mul_b, fm;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] ang;

  logic signed [DW-1:0] vy, vx;
  logic signed [CW-1:0] vx0, vy0, cx_in, cy_in, cx, cy;
  logic signed [AW-1:0] vz0, cz_in, cz, vres, rot_ang, rot_half, rot_z;
  logic [31:0]          h, hp, hz;
  logic                 rot_flip, vec_start, rot_start, cordic_busy, sqrt_busy;
  logic [DW-1:0]        root;
  logic [RW-1:0]        sq_n;
  logic signed [AW-1:0] yaw_d, pitch_d, roll_d, praw;
  logic signed [DW-1:0] cos_v, sin_v;

  assign wi = to_inner(att_q[0]);
  assign xi = to_inner(att_q[1]);
  assign yi = to_inner(att_q[2]);
  assign zi = to_inner(att_q[3]);
  assign u  = unit_q >>> 2;
  assign t  = test_q >>> 1;

  // Select multiplier operands for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQW:  begin mul_a = wi;      mul_b = wi;        end
      OP_SQX:  begin mul_a = xi;      mul_b = xi;        end
      OP_SQY:  begin mul_a = yi;      mul_b = yi;        end
      OP_SQZ:  begin mul_a = zi;      mul_b = zi;        end
      OP_XY:   begin mul_a = xi;      mul_b = yi;        end
      OP_TEST: begin mul_a = zi;      mul_b = wi;        end
      OP_AY:   begin mul_a = DW'(dy_q); mul_b = RAD_SCALE; end
      OP_AP:   begin mul_a = DW'(dp_q); mul_b = RAD_SCALE; end
      OP_AR:   begin mul_a = DW'(dr_q); mul_b = RAD_SCALE; end
      OP_T100: begin mul_a = test_q;  mul_b = POLE_NUM;  end
      OP_U49:  begin mul_a = unit_q;  mul_b = POLE_DEN;  end
      OP_YW:   begin mul_a = yi;      mul_b = wi;        end
      OP_XZ:   begin mul_a = xi;      mul_b = zi;        end
      OP_XW:   begin mul_a = xi;      mul_b = wi;        end
      OP_YZ:   begin mul_a = yi;      mul_b = zi;        end
      OP_UU:   begin mul_a = u;       mul_b = u;         end
      OP_TT:   begin mul_a = t;       mul_b = t;         end
      OP_C1C2: begin mul_a = c1_q;    mul_b = c2_q;      end
      OP_S1S2: begin mul_a = s1_q;    mul_b = s2_q;      end
      OP_S1C2: begin mul_a = s1_q;    mul_b = c2_q;      end
      OP_C1S2: begin mul_a = c1_q;    mul_b = s2_q;      end
      OP_W_A:  begin mul_a = c1c2_q;  mul_b = c3_q;      end
      OP_W_B:  begin mul_a = s1s2_q;  mul_b = s3_q;      end
      OP_X_A:  begin mul_a = c1c2_q;  mul_b = s3_q;      end
      OP_X_B:  begin mul_a = s1s2_q;  mul_b = c3_q;      end
      OP_Y_A:  begin mul_a = s1c2_q;  mul_b = c3_q;      end
      OP_Y_B:  begin mul_a = c1s2_q;  mul_b = s3_q;      end
      OP_Z_A:  begin mul_a = c1s2_q;  mul_b = c3_q;      end
      OP_Z_B:  begin mul_a = s1c2_q;  mul_b = s3_q;      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign fm   = DW'(prod >>> IFRAC);
  assign ang  = AW'((prod + (PW'(1) <<< (ASH - 1))) >>> ASH);

  // Classify the pole case from the scaled test terms
  always_comb begin
    if (m1_q > m2_q) begin
      pole_d = POLE_NORTH;
    end else if (m1_q < -m2_q) begin
      pole_d = POLE_SOUTH;
    end else begin
      pole_d = POLE_NONE;
    end
  end

  // Pick the arctangent arguments
  always_comb begin
    vy = '0;
    vx = '0;
    case (cmd_i.op)
      OP_VEC_YAW: begin
        if (pole_q != POLE_NONE) begin
          vy = xi;
          vx = wi;
        end else begin
          vy = (fyw_q <<< 1) - (fxz_q <<< 1);
          vx = sqx_q - sqy_q - sqz_q + sqw_q;
        end
      end
      OP_VEC_PITCH: begin
        vy = t;
        vx = signed'(root);
      end
      OP_VEC_ROLL: begin
        vy = (fxw_q <<< 1) - (fyz_q <<< 1);
        vx = sqy_q - sqx_q - sqz_q + sqw_q;
      end
      default: ;
    endcase
  end

  // Fold the left half plane onto the right
  always_comb begin
    if (vx < 0) begin
      if (vy >= 0) begin
        vx0 = CW'(vy);
        vy0 = -CW'(vx);
        vz0 = QUARTER;
      end else begin
        vx0 = -CW'(vy);
        vy0 = CW'(vx);
        vz0 = -QUARTER;
      end
    end else begin
      vx0 = CW'(vx);
      vy0 = CW'(vy);
      vz0 = AW'(0);
    end
  end

  // Halve the angle and fold it into the right half turn
  always_comb begin
    case (cmd_i.op)
      OP_ROT_YAW:   rot_ang = yaw_q;
      OP_ROT_PITCH: rot_ang = pitch_q;
      default:      rot_ang = roll_q;
    endcase
  end

  assign rot_half = rot_ang >>> 1;
  assign h        = rot_half[31:0];
  assign hp       = h + 32'h4000_0000;
  assign rot_flip = hp[31];
  assign hz       = rot_flip ? {~h[31], h[30:0]} : h;
  assign rot_z    = AW'(signed'(hz));

  always_comb begin
    vec_start = 1'b0;
    rot_start = 1'b0;
    case (cmd_i.op) inside
      OP_VEC_YAW, OP_VEC_PITCH, OP_VEC_ROLL: vec_start = 1'b1;
      OP_ROT_YAW, OP_ROT_PITCH, OP_ROT_ROLL: rot_start = 1'b1;
      default: ;
    endcase
  end

  assign cx_in = vec_start ? vx0 : CORDIC_K;
  assign cy_in = vec_start ? vy0 : CW'(0);
  assign cz_in = vec_start ? vz0 : rot_z;

  eiqu_cordic u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (vec_start | rot_start),
    .vec_mode_i (vec_start),
    .x_i        (cx_in),
    .y_i        (cy_in),
    .z_i        (cz_in),
    .busy_o     (cordic_busy),
    .x_o        (cx),
    .y_o        (cy),
    .z_o        (cz)
  );

  // Clip a negative radicand to zero
  assign rad  = uu_q - tt_q;
  assign sq_n = (rad < 0) ? '0 : rad;

  eiqu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT),
    .n_i     (sq_n),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign stat_o.busy = cordic_busy | sqrt_busy;

  // Turn unit results into angles, sines and cosines
  assign vres  = vzero_q ? AW'(0) : cz;
  assign cos_v = DW'(flip_q ? -cx : cx);
  assign sin_v = DW'(flip_q ? -cy : cy);

  always_comb begin
    case (pole_q)
      POLE_NORTH: yaw_d = (vres <<< 1) - ay_q;
      POLE_SOUTH: yaw_d = -(vres <<< 1) - ay_q;
      default:    yaw_d = vres - ay_q;
    endcase
  end

  assign praw = vres - ap_q;

  always_comb begin
    case (pole_q)
      POLE_NORTH: pitch_d = PITCH_HI - ((dp_q > 0) ? ap_q : AW'(0));
      POLE_SOUTH: pitch_d = PITCH_LO - ((dp_q < 0) ? ap_q : AW'(0));
      default: begin
        if (praw > PITCH_HI) begin
          pitch_d = PITCH_HI;
        end else if (praw < PITCH_LO) begin
          pitch_d = PITCH_LO;
        end else begin
          pitch_d = praw;
        end
      end
    endcase
  end

  assign roll_d = (pole_q == POLE_NONE) ? (vres - ar_q) : -ar_q;

  // Capture step results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dy_q <= in_word_i.yaw_delta;
      dp_q <= in_word_i.pitch_delta;
      dr_q <= in_word_i.roll_delta;
    end
    case (cmd_i.op) inside
      OP_SQW:       sqw_q   <= fm;
      OP_SQX:       sqx_q   <= fm;
      OP_SQY:       sqy_q   <= fm;
      OP_SQZ:       sqz_q   <= fm;
      OP_XY:        fxy_q   <= fm;
      OP_TEST:      test_q  <= fxy_q + fm;
      OP_UNIT:      unit_q  <= sqw_q + sqx_q + sqy_q + sqz_q;
      OP_AY:        ay_q    <= ang;
      OP_AP:        ap_q    <= ang;
      OP_AR:        ar_q    <= ang;
      OP_T100:      m1_q    <= MPW'(prod);
      OP_U49:       m2_q    <= MPW'(prod);
      OP_POLE:      pole_q  <= pole_d;
      OP_YW:        fyw_q   <= fm;
      OP_XZ:        fxz_q   <= fm;
      OP_XW:        fxw_q   <= fm;
      OP_YZ:        fyz_q   <= fm;
      OP_VEC_YAW, OP_VEC_PITCH, OP_VEC_ROLL:
                    vzero_q <= (vx == 0) && (vy == 0);
      OP_SET_YAW:   yaw_q   <= yaw_d;
      OP_UU:        uu_q    <= RW'(prod);
      OP_TT:        tt_q    <= RW'(prod);
      OP_SET_PITCH: pitch_q <= pitch_d;
      OP_SET_ROLL:  roll_q  <= roll_d;
      OP_ROT_YAW, OP_ROT_PITCH, OP_ROT_ROLL:
                    flip_q  <= rot_flip;
      OP_SET_1:     begin c1_q <= cos_v; s1_q <= sin_v; end
      OP_SET_2:     begin c2_q <= cos_v; s2_q <= sin_v; end
      OP_SET_3:     begin c3_q <= cos_v; s3_q <= sin_v; end
      OP_C1C2:      c1c2_q  <= fm;
      OP_S1S2:      s1s2_q  <= fm;
      OP_S1C2:      s1c2_q  <= fm;
      OP_C1S2:      c1s2_q  <= fm;
      OP_W_A, OP_X_A, OP_Y_A, OP_Z_A:
                    pa_q    <= fm;
      OP_W_B:       pd_q[0] <= pa_q - fm;
      OP_X_B:       pd_q[1] <= pa_q + fm;
      OP_Y_B:       pd_q[2] <= pa_q + fm;
      OP_Z_B:       pd_q[3] <= pa_q - fm;
      default: ;
    endcase
  end

  // Hold the attitude, identity after reset; it doubles as the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q[0] <= QUAT_BITS'(QMAX);
      att_q[1] <= '0;
      att_q[2] <= '0;
      att_q[3] <= '0;
    end else if (cmd_i.store) begin
      att_q[0] <= to_outer(pd_q[0]);
      att_q[1] <= to_outer(pd_q[1]);
      att_q[2] <= to_outer(pd_q[2]);
      att_q[3] <= to_outer(pd_q[3]);
    end
  end

  assign out_word_o.quat_w = att_q[0];
  assign out_word_o.quat_x = att_q[1];
  assign out_word_o.quat_y = att_q[2];
  assign out_word_o.quat_z = att_q[3];

endmodule

@@ hdl/eiqu_ctrl.sv @@
// Controller: step sequencer, unit waits and output word handshake.
module eiqu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output eiqu_pkg::cmd_t  cmd_o,
  input  eiqu_pkg::stat_t stat_i
);
  import eiqu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_FIN} state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            out_valid_q, out_valid_d;
  op_e             op;
  logic            do_store;

  assign op       = (state_q == S_RUN) ? prog_op(pc_q) : OP_NONE;
  assign do_store = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Present a stored word until it is taken
  assign out_valid_d = do_store || (out_valid_q && !out_ready_i);

  assign cmd_o.op    = op;
  assign cmd_o.load  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.store = do_store;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Step through the program, hold while a unit runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pc_q    <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (pc_q == PC_W'(PROG_LEN - 1)) begin
            state_q <= S_FIN;
          end else begin
            pc_q <= pc_q + 1'b1;
            if (op_waits(op)) begin
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (!stat_i.busy) begin
            state_q <= S_RUN;
          end
        end
        S_FIN: begin
          if (do_store) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/euler_increment_quaternion_update_core.sv @@
// From the accepting edge of an input word to out_valid_o the core runs 44 program
// steps, six 30-step CORDIC runs and one 32-step square root, each with a hand-off,
// and one store.
// The sequential step program takes a new word only after the previous one is stored.
// A new input word is taken while the previous output word still waits.
// Reset sets the attitude to identity (w largest value below one, x y z zero).
module euler_increment_quaternion_update_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  eiqu_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output eiqu_pkg::out_word_t out_word_o
);
  import eiqu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  eiqu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  eiqu_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

  // No unit may still be running while a new word can be taken
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.busy)
    else $error("unit busy while ready for a new word");

  // A store never overwrites a word that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> !(out_valid_o && !out_ready_i))
    else $error("output word overwritten");

  // A store presents a word in the next cycle
  a_store_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |=> out_valid_o)
    else $error("stored word not presented");

  // An accepted word closes the input until its work is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened while busy");

endmodule

@@ test/attitude_update_checker.sv @@
// Checker for the attitude update core: predicts each output word and compares it.
`timescale 1ns / 1ps
module attitude_update_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  eiqu_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  eiqu_pkg::out_word_t out_word_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  import eiqu_pkg::*;

  localparam longint ONE_TURN_MASK = 64'hFFFF_FFFF;
  localparam longint RAD_K    = 64'd2734261102;
  localparam longint P_HI     = 64'sd1073607622;
  localparam longint P_LO     = -64'sd1073744335;
  localparam longint QTR      = 64'sd1073741824;
  localparam longint GAIN     = 64'sd652032874;

  longint    attitude_q[4];
  out_word_t quat_expected_q[$];

  // Arctangent table in angle units, 2^32 per turn
  function automatic longint atan_step(input int i);
    longint tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
      20, 10, 5, 3, 1};
    return tab[i];
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> IFRAC;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(input longint yv, input longint xv);
    longint z, t;
    z = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; z = QTR;
      end else begin
        t = xv; xv = -yv; yv = t; z = -QTR;
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      if (yv > 0) begin
        t = xv + (yv >>> i); yv = yv - (xv >>> i); xv = t; z += atan_step(i);
      end else begin
        t = xv - (yv >>> i); yv = yv + (xv >>> i); xv = t; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // Cosine and sine of half an unwrapped angle
  task automatic half_angle_trig(input longint angle, output longint c, output longint s);
    longint h, xv, yv, z, t;
    logic   flip;
    h = (angle >>> 1) & ONE_TURN_MASK;
    flip = (((h + 64'h4000_0000) & ONE_TURN_MASK) & 64'h8000_0000) != 0;
    if (flip) h = (h - 64'h8000_0000) & ONE_TURN_MASK;
    z = h;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    xv = GAIN;
    yv = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        t = xv - (yv >>> i); yv = yv + (xv >>> i); xv = t; z -= atan_step(i);
      end else begin
        t = xv + (yv >>> i); yv = yv - (xv >>> i); xv = t; z += atan_step(i);
      end
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endtask

  function automatic longint to_quat(input longint v);
    longint r;
    r = round_shift(v, IFRAC - QFRAC);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Advance the attitude by one word of increments and return the new quaternion
  task automatic update_attitude(input in_word_t d, output out_word_t q);
    longint dy, dp, dr, w, x, y, z, sqw, sqx, sqy, sqz, unit, test;
    longint ay, ap, ar, yaw, pitch, roll, u, t, rad;
    longint c1, s1, c2, s2, c3, s3, c1c2, s1s2, s1c2, c1s2, res[4];
    dy = d.yaw_delta; dp = d.pitch_delta; dr = d.roll_delta;
    w = attitude_q[0] <<< (IFRAC - QFRAC); x = attitude_q[1] <<< (IFRAC - QFRAC);
    y = attitude_q[2] <<< (IFRAC - QFRAC); z = attitude_q[3] <<< (IFRAC - QFRAC);
    sqw = fmul(w, w); sqx = fmul(x, x); sqy = fmul(y, y); sqz = fmul(z, z);
    unit = sqw + sqx + sqy + sqz;
    test = fmul(x, y) + fmul(z, w);
    ay = round_shift(dy * RAD_K, AFRAC + 2);
    ap = round_shift(dp * RAD_K, AFRAC + 2);
    ar = round_shift(dr * RAD_K, AFRAC + 2);
    if (test * 100000 > unit * 49999) begin
      // north pole: only a positive pitch increment applies
      yaw = 2 * vector_angle(x, w);
      pitch = P_HI;
      if (dp > 0) pitch -= ap;
      roll = 0;
    end else if (test * 100000 < -(unit * 49999)) begin
      // south pole: only a negative pitch increment applies
      yaw = -2 * vector_angle(x, w);
      pitch = P_LO;
      if (dp < 0) pitch -= ap;
      roll = 0;
    end else begin
      u = unit >>> 2;
      t = (2 * test) >>> 2;
      yaw = vector_angle(2 * fmul(y, w) - 2 * fmul(x, z), sqx - sqy - sqz + sqw);
      rad = u * u - t * t;
      if (rad < 0) rad = 0;
      pitch = vector_angle(t, longint'(int_sqrt(rad))) - ap;
      if (pitch > P_HI) pitch = P_HI;
      else if (pitch < P_LO) pitch = P_LO;
      roll = vector_angle(2 * fmul(x, w) - 2 * fmul(y, z), -sqx + sqy - sqz + sqw);
    end
    yaw -= ay;
    roll -= ar;
    half_angle_trig(yaw, c1, s1);
    half_angle_trig(pitch, c2, s2);
    half_angle_trig(roll, c3, s3);
    c1c2 = fmul(c1, c2); s1s2 = fmul(s1, s2);
    s1c2 = fmul(s1, c2); c1s2 = fmul(c1, s2);
    res[0] = to_quat(fmul(c1c2, c3) - fmul(s1s2, s3));
    res[1] = to_quat(fmul(c1c2, s3) + fmul(s1s2, c3));
    res[2] = to_quat(fmul(s1c2, c3) + fmul(c1s2, s3));
    res[3] = to_quat(fmul(c1s2, c3) - fmul(s1c2, s3));
    for (int k = 0; k < 4; k++) attitude_q[k] = res[k];
    q.quat_w = res[0][15:0]; q.quat_x = res[1][15:0];
    q.quat_y = res[2][15:0]; q.quat_z = res[3][15:0];
  endtask

  // Compare output words first, then predict the next one
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w, new_w;
    if (!rst_ni) begin
      attitude_q[0] = 32767;
      attitude_q[1] = 0;
      attitude_q[2] = 0;
      attitude_q[3] = 0;
      quat_expected_q.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (quat_expected_q.size() == 0) begin
          $error("output word with no prediction waiting: %h", out_word_i);
          mismatches_o++;
        end else begin
          exp_w = quat_expected_q.pop_front();
          if (out_word_i.quat_w !== exp_w.quat_w) begin
            $error("quat_w expected %0d got %0d", exp_w.quat_w, out_word_i.quat_w);
            mismatches_o++;
          end
          if (out_word_i.quat_x !== exp_w.quat_x) begin
            $error("quat_x expected %0d got %0d", exp_w.quat_x, out_word_i.quat_x);
            mismatches_o++;
          end
          if (out_word_i.quat_y !== exp_w.quat_y) begin
            $error("quat_y expected %0d got %0d", exp_w.quat_y, out_word_i.quat_y);
            mismatches_o++;
          end
          if (out_word_i.quat_z !== exp_w.quat_z) begin
            $error("quat_z expected %0d got %0d", exp_w.quat_z, out_word_i.quat_z);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        update_attitude(in_word_i, new_w);
        quat_expected_q.push_back(new_w);
      end
      pending_o = quat_expected_q.size();
    end
  end

endmodule

@@ test/euler_increment_quaternion_update_core_tb.sv @@
// Testbench top for the attitude update core: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module euler_increment_quaternion_update_core_tb;
  import eiqu_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int QUIET_WORDS  = 200;
  localparam int STALL_LIMIT  = 3000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  logic      quiet;
  int        mismatches;
  int        pending;
  int        stall_cycles;

  euler_increment_quaternion_update_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  attitude_update_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Stall the output side in short random bursts, never in the quiet tail
  initial begin
    int gap;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive one word and hold it until taken
  task automatic send_word(input logic [15:0] yd, input logic [15:0] pd, input logic [15:0] rd);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word.yaw_delta   <= yd;
    in_word.pitch_delta <= pd;
    in_word.roll_delta  <= rd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: zero step, field extremes, both poles reached and pushed
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(16'h7FFF, 16'sd0, 16'sd0);
    send_word(16'h8000, 16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd0, 16'h7FFF);
    send_word(16'sd0, 16'sd0, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000, 16'h8000);
    send_word(16'sd0, -16'sd8192, 16'sd0);
    send_word(16'sd500, -16'sd100, 16'sd300);
    send_word(16'sd200, 16'sd100, -16'sd300);
    send_word(16'sd0, -16'sd8192, 16'sd0);
    send_word(16'sd0, 16'sd4000, 16'sd0);
    send_word(16'sd0, 16'sd8192, 16'sd0);
    send_word(-16'sd500, 16'sd100, 16'sd300);
    send_word(16'sd200, -16'sd100, -16'sd300);
    send_word(16'sd0, 16'sd8192, 16'sd0);
    send_word(16'sd0, -16'sd4000, 16'sd0);
    send_word(16'sd1, 16'sd1, 16'sd1);
    send_word(-16'sd1, -16'sd1, -16'sd1);
    send_word(16'h5555, 16'hAAAA, 16'h5555);
    send_word(16'hAAAA, 16'h5555, 16'hAAAA);

    // Let every prediction land before the random part
    drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_word(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 4000) - 2000),
                  16'($urandom_range(0, 4000) - 2000));
      end else if (pick < 7) begin
        send_word(16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 9) begin
        // hold the pitch at a pole, then nudge it either way
        send_word(16'($urandom_range(0, 1000) - 500),
                  ($urandom_range(0, 1) != 0) ? 16'sd8192 : -16'sd8192,
                  16'($urandom_range(0, 1000) - 500));
      end else begin
        send_word(16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100),
                  16'($urandom_range(0, 200) - 100));
      end
    end

    drain();
    repeat (300) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
